// ===== rtl/gauss_jordan_reduce_invert_defines.svh =====
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef GAUSS_JORDAN_REDUCE_INVERT_DEFINES_SVH
`define GAUSS_JORDAN_REDUCE_INVERT_DEFINES_SVH

// same-cycle implication
`define GJRI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gjri: implication check failed");

// next-cycle implication
`define GJRI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gjri: next-cycle check failed");

`endif

// ===== rtl/gjri_pkg.sv =====
package gjri_pkg;

  localparam int MAX_DIM    = 8;
  localparam int STORE_COLS = 2 * MAX_DIM;
  localparam int ROW_W      = $clog2(MAX_DIM);
  localparam int COL_W      = $clog2(STORE_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_DIM * STORE_COLS;

  localparam logic signed [31:0] Q_ONE = 32'sh0100_0000;

  typedef enum logic [1:0] {
    OPC_LOAD = 2'd0,
    OPC_RUN  = 2'd1,
    OPC_READ = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_RANGE    = 2'd2,
    ST_COLS     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_INVERT_MODE  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [2:0]         row_index;
    logic [3:0]         column_index;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [2:0] {
    DP_SCAL,
    DP_IDENT,
    DP_COPY,
    DP_ADD,
    DP_NORM,
    DP_ELIM,
    DP_BACK
  } dp_op_t;

  typedef struct packed {
    logic              valid;
    dp_op_t            op;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] addr_w;
    logic              one;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDENT,
    S_PIV,
    S_SRCH,
    S_ADD,
    S_NORM,
    S_EREAD,
    S_ELIM,
    S_FREAD,
    S_BACK,
    S_COPY,
    S_DONE
  } ctl_state_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_READ,
    P_DIV,
    P_DIVFIN,
    P_RND,
    P_BACKFIN
  } dp_phase_t;

endpackage

// ===== rtl/gjri_datapath.sv =====
module gjri_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gjri_pkg::dp_cmd_t         cmd,
  output gjri_pkg::dp_sts_t         sts,
  input  logic                      ext_we,
  input  logic [gjri_pkg::ADDR_W-1:0] ext_waddr,
  input  logic signed [31:0]        ext_wdata,
  input  logic [gjri_pkg::ADDR_W-1:0] ext_raddr,
  output logic signed [31:0]        rd_data
);

  localparam int DIV_STEPS = 56;

  logic signed [31:0] mem [gjri_pkg::DEPTH];
  logic signed [31:0] rdata_a_r, rdata_b_r;

  gjri_pkg::dp_phase_t phase_r, phase_nxt;
  gjri_pkg::dp_op_t    op_r, op_nxt;
  logic [gjri_pkg::ADDR_W-1:0] waddr_r, waddr_nxt;
  logic one_r, one_nxt;
  logic signed [31:0] scal_r, scal_nxt, a_r, a_nxt, b_r, b_nxt, term_r, term_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [55:0] num_r, num_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic signed [63:0] prod_r, prod_nxt;

  logic int_we, we;
  logic signed [31:0] int_wdata, wdata;
  logic [gjri_pkg::ADDR_W-1:0] waddr, raddr_a;

  function automatic logic signed [31:0] sat33(logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    else if (v < -33'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] qadd(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) + $signed({b[31], b});
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qsub(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = $signed({a[31], a}) - $signed({b[31], b});
    return sat33(s);
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // signed result of a magnitude and a sign, saturated
  function automatic logic signed [31:0] sat_mag(logic big, logic [31:0] m, logic neg);
    if (!neg) begin
      return (big || m[31]) ? 32'sh7fffffff : m;
    end else begin
      return (big || (m[31] && |m[30:0])) ? 32'sh80000000 : (~m + 32'd1);
    end
  endfunction

  assign we      = int_we | ext_we;
  assign waddr   = int_we ? waddr_r : ext_waddr;
  assign wdata   = int_we ? int_wdata : ext_wdata;
  assign raddr_a = cmd.valid ? cmd.addr_a : ext_raddr;
  assign rd_data = rdata_a_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[cmd.addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= gjri_pkg::P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    waddr_r <= waddr_nxt;
    one_r   <= one_nxt;
    scal_r  <= scal_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    term_r  <= term_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    num_r   <= num_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    prod_r  <= prod_nxt;
  end

  always_comb begin
    logic [32:0] rem_sh;
    logic        ge;
    logic [63:0] pm, pr;
    logic signed [31:0] quot;
    phase_nxt = phase_r;
    op_nxt    = op_r;
    waddr_nxt = waddr_r;
    one_nxt   = one_r;
    scal_nxt  = scal_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    term_nxt  = term_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    prod_nxt  = prod_r;
    int_we    = 1'b0;
    int_wdata = '0;
    sts       = '0;
    rem_sh    = {rem_r[31:0], num_r[55]};
    ge        = rem_sh >= {1'b0, den_r};
    pm        = prod_r[63] ? (~prod_r + 64'd1) : prod_r;
    pr        = (pm + 64'd8388608) >> 24;
    quot      = sat_mag(|num_r[55:32], num_r[31:0], neg_r);
    unique case (phase_r)
      gjri_pkg::P_IDLE: begin
        if (cmd.valid) begin
          op_nxt    = cmd.op;
          waddr_nxt = cmd.addr_w;
          one_nxt   = cmd.one;
          phase_nxt = gjri_pkg::P_READ;
        end
      end
      gjri_pkg::P_READ: begin
        a_nxt     = rdata_a_r;
        b_nxt     = rdata_b_r;
        phase_nxt = gjri_pkg::P_IDLE;
        unique case (op_r)
          gjri_pkg::DP_SCAL: begin
            scal_nxt = rdata_a_r;
            sts.done = 1'b1;
            sts.zero = (rdata_a_r == 32'sd0);
          end
          gjri_pkg::DP_IDENT: begin
            int_we    = 1'b1;
            int_wdata = one_r ? gjri_pkg::Q_ONE : 32'sd0;
            sts.done  = 1'b1;
          end
          gjri_pkg::DP_COPY: begin
            int_we    = 1'b1;
            int_wdata = rdata_a_r;
            sts.done  = 1'b1;
          end
          gjri_pkg::DP_ADD: begin
            int_we    = 1'b1;
            int_wdata = qadd(rdata_a_r, rdata_b_r);
            sts.done  = 1'b1;
          end
          gjri_pkg::DP_NORM, gjri_pkg::DP_ELIM: begin
            den_nxt = mag32(scal_r);
            rem_nxt = '0;
            neg_nxt = rdata_a_r[31] ^ scal_r[31];
            cnt_nxt = 6'(DIV_STEPS);
            if (scal_r == 32'sd0) begin
              num_nxt   = '0;
              phase_nxt = gjri_pkg::P_DIVFIN;
            end else begin
              num_nxt   = {mag32(rdata_a_r), 24'd0} + {25'd0, den_nxt[31:1]};
              phase_nxt = gjri_pkg::P_DIV;
            end
          end
          gjri_pkg::DP_BACK: begin
            prod_nxt  = rdata_b_r * scal_r;
            phase_nxt = gjri_pkg::P_RND;
          end
          default: begin
            sts.done = 1'b1;
          end
        endcase
      end
      gjri_pkg::P_DIV: begin
        rem_nxt = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        num_nxt = {num_r[54:0], ge};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          phase_nxt = gjri_pkg::P_DIVFIN;
        end
      end
      gjri_pkg::P_DIVFIN: begin
        int_we    = 1'b1;
        int_wdata = (op_r == gjri_pkg::DP_ELIM) ? qsub(quot, b_r) : quot;
        sts.done  = 1'b1;
        phase_nxt = gjri_pkg::P_IDLE;
      end
      gjri_pkg::P_RND: begin
        term_nxt  = sat_mag(|pr[39:32], pr[31:0], prod_r[63]);
        phase_nxt = gjri_pkg::P_BACKFIN;
      end
      gjri_pkg::P_BACKFIN: begin
        int_we    = 1'b1;
        int_wdata = qsub(a_r, term_r);
        sts.done  = 1'b1;
        phase_nxt = gjri_pkg::P_IDLE;
      end
      default: begin
        phase_nxt = gjri_pkg::P_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/gjri_ctrl.sv =====
`include "gauss_jordan_reduce_invert_defines.svh"

module gjri_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       run_go,
  input  logic [gjri_pkg::ROW_W:0]   h,
  input  logic [gjri_pkg::COL_W:0]   w,
  input  logic                       inv,
  input  gjri_pkg::dp_sts_t          sts,
  output gjri_pkg::dp_cmd_t          cmd,
  output logic                       busy,
  output logic                       fin,
  output gjri_pkg::status_t          fin_status,
  output gjri_pkg::status_t          run_status
);

  localparam int RW = gjri_pkg::ROW_W;
  localparam int CW = gjri_pkg::COL_W;

  gjri_pkg::ctl_state_t state_r, state_nxt;
  logic wait_r, wait_nxt;
  logic [RW-1:0] c_r, c_nxt, r_r, r_nxt, s_r, s_nxt;
  logic [CW-1:0] j_r, j_nxt;
  gjri_pkg::status_t st_r, st_nxt, run_status_r, run_status_nxt;

  logic [RW:0]   hm1_full;
  logic [RW-1:0] hm1;
  logic [CW:0]   wm1_full;
  logic [CW-1:0] wm1;
  logic [CW-1:0] hcol;

  function automatic logic [gjri_pkg::ADDR_W-1:0] mk_addr(logic [RW-1:0] row,
                                                          logic [CW-1:0] col);
    return {row, col};
  endfunction

  assign hm1_full   = h - (RW+1)'(1);
  assign hm1        = hm1_full[RW-1:0];
  assign wm1_full   = w - (CW+1)'(1);
  assign wm1        = wm1_full[CW-1:0];
  assign hcol       = h[CW-1:0] + j_r;
  assign busy       = (state_r != gjri_pkg::S_IDLE);
  assign fin        = (state_r == gjri_pkg::S_DONE);
  assign fin_status = st_r;
  assign run_status = run_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gjri_pkg::S_IDLE;
      wait_r       <= 1'b0;
      run_status_r <= gjri_pkg::ST_OK;
    end else begin
      state_r      <= state_nxt;
      wait_r       <= wait_nxt;
      run_status_r <= run_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r  <= c_nxt;
    r_r  <= r_nxt;
    s_r  <= s_nxt;
    j_r  <= j_nxt;
    st_r <= st_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    c_nxt          = c_r;
    r_nxt          = r_r;
    s_nxt          = s_r;
    j_nxt          = j_r;
    st_nxt         = st_r;
    run_status_nxt = run_status_r;
    cmd            = '0;
    cmd.op         = gjri_pkg::DP_SCAL;
    cmd.valid      = busy && !fin && !wait_r;
    wait_nxt       = wait_r;
    if (cmd.valid) wait_nxt = 1'b1;
    if (sts.done) wait_nxt = 1'b0;

    unique case (state_r)
      gjri_pkg::S_IDLE: begin
        if (run_go) begin
          c_nxt = '0;
          r_nxt = '0;
          j_nxt = '0;
          if (inv) begin
            state_nxt = gjri_pkg::S_IDENT;
          end else if ({1'b0, h} > w) begin
            st_nxt    = gjri_pkg::ST_COLS;
            state_nxt = gjri_pkg::S_DONE;
          end else begin
            state_nxt = gjri_pkg::S_PIV;
          end
        end
      end
      gjri_pkg::S_IDENT: begin
        cmd.op     = gjri_pkg::DP_IDENT;
        cmd.addr_w = mk_addr(r_r, hcol);
        cmd.one    = (r_r == j_r[RW-1:0]);
        if (sts.done) begin
          if (j_r[RW-1:0] == hm1) begin
            j_nxt = '0;
            if (r_r == hm1) begin
              c_nxt     = '0;
              state_nxt = gjri_pkg::S_PIV;
            end else begin
              r_nxt = r_r + RW'(1);
            end
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end
      end
      gjri_pkg::S_PIV: begin
        cmd.addr_a = mk_addr(c_r, CW'(c_r));
        if (sts.done) begin
          j_nxt = '0;
          if (sts.zero) begin
            if (c_r == hm1) begin
              st_nxt    = gjri_pkg::ST_SINGULAR;
              state_nxt = gjri_pkg::S_DONE;
            end else begin
              s_nxt     = c_r + RW'(1);
              state_nxt = gjri_pkg::S_SRCH;
            end
          end else begin
            state_nxt = gjri_pkg::S_NORM;
          end
        end
      end
      gjri_pkg::S_SRCH: begin
        cmd.addr_a = mk_addr(s_r, CW'(c_r));
        if (sts.done) begin
          if (!sts.zero) begin
            j_nxt     = '0;
            state_nxt = gjri_pkg::S_ADD;
          end else if (s_r == hm1) begin
            st_nxt    = gjri_pkg::ST_SINGULAR;
            state_nxt = gjri_pkg::S_DONE;
          end else begin
            s_nxt = s_r + RW'(1);
          end
        end
      end
      gjri_pkg::S_ADD: begin
        cmd.op     = gjri_pkg::DP_ADD;
        cmd.addr_a = mk_addr(c_r, j_r);
        cmd.addr_b = mk_addr(s_r, j_r);
        cmd.addr_w = mk_addr(c_r, j_r);
        if (sts.done) begin
          if (j_r == wm1) begin
            j_nxt     = '0;
            state_nxt = gjri_pkg::S_PIV;
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end
      end
      gjri_pkg::S_NORM: begin
        cmd.op     = gjri_pkg::DP_NORM;
        cmd.addr_a = mk_addr(c_r, j_r);
        cmd.addr_w = mk_addr(c_r, j_r);
        if (sts.done) begin
          if (j_r == wm1) begin
            j_nxt = '0;
            if (c_r != hm1) begin
              r_nxt     = c_r + RW'(1);
              state_nxt = gjri_pkg::S_EREAD;
            end else if (c_r == '0) begin
              // single row: nothing above the pivot
              if (inv) begin
                r_nxt     = '0;
                state_nxt = gjri_pkg::S_COPY;
              end else begin
                st_nxt    = gjri_pkg::ST_OK;
                state_nxt = gjri_pkg::S_DONE;
              end
            end else begin
              c_nxt     = hm1 - RW'(1);
              r_nxt     = hm1;
              state_nxt = gjri_pkg::S_FREAD;
            end
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end
      end
      gjri_pkg::S_EREAD, gjri_pkg::S_ELIM: begin
        if (state_r == gjri_pkg::S_ELIM) begin
          cmd.op     = gjri_pkg::DP_ELIM;
          cmd.addr_a = mk_addr(r_r, j_r);
          cmd.addr_b = mk_addr(c_r, j_r);
          cmd.addr_w = mk_addr(r_r, j_r);
        end else begin
          cmd.addr_a = mk_addr(r_r, CW'(c_r));
        end
        if (sts.done) begin
          if (state_r == gjri_pkg::S_EREAD && !sts.zero) begin
            j_nxt     = '0;
            state_nxt = gjri_pkg::S_ELIM;
          end else if (state_r == gjri_pkg::S_ELIM && j_r != wm1) begin
            j_nxt = j_r + CW'(1);
          end else begin
            j_nxt = '0;
            if (r_r == hm1) begin
              c_nxt     = c_r + RW'(1);
              state_nxt = gjri_pkg::S_PIV;
            end else begin
              r_nxt     = r_r + RW'(1);
              state_nxt = gjri_pkg::S_EREAD;
            end
          end
        end
      end
      gjri_pkg::S_FREAD: begin
        cmd.addr_a = mk_addr(c_r, CW'(r_r));
        if (sts.done) begin
          j_nxt     = '0;
          state_nxt = gjri_pkg::S_BACK;
        end
      end
      gjri_pkg::S_BACK: begin
        cmd.op     = gjri_pkg::DP_BACK;
        cmd.addr_a = mk_addr(c_r, j_r);
        cmd.addr_b = mk_addr(r_r, j_r);
        cmd.addr_w = mk_addr(c_r, j_r);
        if (sts.done) begin
          if (j_r == wm1) begin
            j_nxt = '0;
            if (r_r != c_r + RW'(1)) begin
              r_nxt     = r_r - RW'(1);
              state_nxt = gjri_pkg::S_FREAD;
            end else if (c_r != '0) begin
              c_nxt     = c_r - RW'(1);
              r_nxt     = hm1;
              state_nxt = gjri_pkg::S_FREAD;
            end else if (inv) begin
              r_nxt     = '0;
              state_nxt = gjri_pkg::S_COPY;
            end else begin
              st_nxt    = gjri_pkg::ST_OK;
              state_nxt = gjri_pkg::S_DONE;
            end
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end
      end
      gjri_pkg::S_COPY: begin
        cmd.op     = gjri_pkg::DP_COPY;
        cmd.addr_a = mk_addr(r_r, hcol);
        cmd.addr_w = mk_addr(r_r, j_r);
        if (sts.done) begin
          if (j_r[RW-1:0] == hm1) begin
            j_nxt = '0;
            if (r_r == hm1) begin
              st_nxt    = gjri_pkg::ST_OK;
              state_nxt = gjri_pkg::S_DONE;
            end else begin
              r_nxt = r_r + RW'(1);
            end
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end
      end
      gjri_pkg::S_DONE: begin
        run_status_nxt = st_r;
        state_nxt      = gjri_pkg::S_IDLE;
      end
      default: begin
        state_nxt = gjri_pkg::S_IDLE;
      end
    endcase
  end

  `GJRI_ASSERT_IMP(a_done_only_when_waiting, sts.done, wait_r)
  `GJRI_ASSERT_NXT(a_done_returns_idle, state_r == gjri_pkg::S_DONE, state_r == gjri_pkg::S_IDLE && !wait_r)
  `GJRI_ASSERT_IMP(a_col_in_range, busy && !fin, j_r <= wm1)
  `GJRI_ASSERT_IMP(a_cols_not_invert, fin && st_r == gjri_pkg::ST_COLS, !inv)

endmodule

// ===== rtl/gauss_jordan_reduce_invert.sv =====
// Channel   Ports                                   Transfer
// input     start, busy, in_item                    start && !busy
// result    out_valid, out_item                     out_valid, one cycle
// config    cfg_we, cfg_index, cfg_data             cfg_we
//
// Load and read items give their result in the cycle after accept.
// A run holds busy for the whole elimination: each element update is a store
// read, one operation and a write; the normalize and eliminate steps use the
// 1-bit-per-cycle divider.
// Reset is synchronous, active low; the matrix store is not cleared.
// Results are shown for one cycle and cannot be held off.
module gauss_jordan_reduce_invert (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gjri_pkg::in_item_t  in_item,
  output logic                out_valid,
  output gjri_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [4:0]          cfg_data
);

  localparam int RW = gjri_pkg::ROW_W;
  localparam int CW = gjri_pkg::COL_W;

  logic [3:0] row_count_r;
  logic [4:0] column_count_r;
  logic       invert_mode_r;

  logic [RW:0] h_eff;
  logic [CW:0] w_cols, w_run, w_bound;
  logic        accept, in_range, run_go, ext_we, ctl_busy, fin;
  gjri_pkg::status_t fin_status, run_status;
  gjri_pkg::dp_cmd_t cmd;
  gjri_pkg::dp_sts_t sts;
  logic signed [31:0] rd_data;
  logic [gjri_pkg::ADDR_W-1:0] ext_addr;

  logic out_valid_r, out_valid_nxt, out_rd_r, out_rd_nxt;
  gjri_pkg::status_t out_status_r, out_status_nxt;

  always_comb begin
    if (row_count_r == 4'd0) h_eff = (RW+1)'(1);
    else if (row_count_r > 4'(gjri_pkg::MAX_DIM)) h_eff = (RW+1)'(gjri_pkg::MAX_DIM);
    else h_eff = row_count_r[RW:0];
    if (column_count_r == 5'd0) w_cols = (CW+1)'(1);
    else if (column_count_r > 5'(gjri_pkg::STORE_COLS)) w_cols = (CW+1)'(gjri_pkg::STORE_COLS);
    else w_cols = column_count_r[CW:0];
  end

  assign w_run    = invert_mode_r ? {h_eff, 1'b0} : w_cols;
  assign w_bound  = invert_mode_r ? {1'b0, h_eff} : w_cols;
  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_item.row_index} < h_eff) &&
                    ({1'b0, in_item.column_index} < w_bound);
  assign run_go   = accept && (in_item.opcode == gjri_pkg::OPC_RUN);
  assign ext_we   = accept && (in_item.opcode == gjri_pkg::OPC_LOAD) && in_range;
  assign ext_addr = {in_item.row_index, in_item.column_index};
  assign busy     = ctl_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r    <= 4'd8;
      column_count_r <= 5'd16;
      invert_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gjri_pkg::CFG_ROW_COUNT:    row_count_r    <= cfg_data[3:0];
        gjri_pkg::CFG_COLUMN_COUNT: column_count_r <= cfg_data;
        gjri_pkg::CFG_INVERT_MODE:  invert_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt  = fin || (accept && (in_item.opcode != gjri_pkg::OPC_RUN));
    out_rd_nxt     = accept && (in_item.opcode == gjri_pkg::OPC_READ) && in_range;
    out_status_nxt = gjri_pkg::ST_RANGE;
    if (fin) begin
      out_status_nxt = fin_status;
    end else if (in_range) begin
      unique case (in_item.opcode)
        gjri_pkg::OPC_LOAD: out_status_nxt = gjri_pkg::ST_OK;
        gjri_pkg::OPC_READ: out_status_nxt = run_status;
        default:            out_status_nxt = gjri_pkg::ST_RANGE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rd_r     <= out_rd_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_item.read_value = out_rd_r ? rd_data : 32'sd0;
  assign out_item.status     = out_status_r;

  gjri_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .run_go     (run_go),
    .h          (h_eff),
    .w          (w_run),
    .inv        (invert_mode_r),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (ctl_busy),
    .fin        (fin),
    .fin_status (fin_status),
    .run_status (run_status)
  );

  gjri_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .ext_we    (ext_we),
    .ext_waddr (ext_addr),
    .ext_wdata (in_item.element_value),
    .ext_raddr (ext_addr),
    .rd_data   (rd_data)
  );

endmodule
